>>> design/ymc_pkg.sv
`timescale 1ns / 1ps
package ymc_pkg;

  localparam int ADDR_BITS_DEFAULT = 20;
  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_RESULTS = 4;

  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_STX = 8'h02;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_C   = 8'h43;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_CANCEL  = 3'd2;
  localparam logic [2:0] ST_ERRLIM  = 3'd3;
  localparam logic [2:0] ST_DESYNC  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  localparam logic [1:0] CFG_BUFFER_SIZE = 2'd0;
  localparam logic [1:0] CFG_ERROR_LIMIT = 2'd1;

  localparam logic [20:0] BUFFER_SIZE_RESET = 21'd1048576;
  localparam logic [3:0]  ERROR_LIMIT_RESET = 4'd10;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [19:0] address;
    logic [2:0]  status;
    logic [20:0] byte_count;
  } result_t;

  typedef struct packed {
    logic [2:0] count;
    result_t [MAX_RESULTS-1:0] res;
  } group_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic result_t mk_send(input logic [7:0] b);
    result_t r;
    r = '0;
    r.kind = KIND_TX;
    r.value = b;
    return r;
  endfunction

endpackage

>>> design/ymc_front.sv
`timescale 1ns / 1ps
module ymc_front (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  logic operation,
  input  logic [7:0] rx_byte,
  input  logic cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [20:0] cfg_data,
  output logic grp_push,
  output ymc_pkg::group_t grp
);
  import ymc_pkg::*;

  logic [20:0] buffer_size;
  logic [3:0]  error_limit;
  logic in_packet, expect_zero, eot_seen, can_seen, large_packet, all_zero, complement_bad;
  logic [3:0]  error_count;
  logic [7:0]  expected_block, block_byte, crc_high_byte;
  logic [20:0] committed_bytes;
  logic [10:0] byte_index;
  logic [15:0] running_crc;

  logic in_packet_next, expect_zero_next, eot_seen_next, can_seen_next;
  logic large_packet_next, all_zero_next, complement_bad_next;
  logic [3:0]  error_count_next;
  logic [7:0]  expected_block_next, block_byte_next, crc_high_byte_next;
  logic [20:0] committed_bytes_next;
  logic [10:0] byte_index_next;
  logic [15:0] running_crc_next;

  logic [2:0] n;
  result_t [MAX_RESULTS-1:0] res;

  always_comb begin
    logic err_req, cancel_req, end_req, crc_ok;
    logic [2:0] st;
    logic [10:0] size;
    logic [21:0] need;
    logic [3:0] ec;
    logic [19:0] addr;
    in_packet_next = in_packet;
    expect_zero_next = expect_zero;
    eot_seen_next = eot_seen;
    can_seen_next = can_seen;
    large_packet_next = large_packet;
    all_zero_next = all_zero;
    complement_bad_next = complement_bad;
    error_count_next = error_count;
    expected_block_next = expected_block;
    block_byte_next = block_byte;
    crc_high_byte_next = crc_high_byte;
    committed_bytes_next = committed_bytes;
    byte_index_next = byte_index;
    running_crc_next = running_crc;
    n = 3'd0;
    res = '0;
    err_req = 1'b0;
    cancel_req = 1'b0;
    end_req = 1'b0;
    st = ST_OK;
    ec = error_count;
    size = large_packet ? 11'd1024 : 11'd128;
    crc_ok = (running_crc[15:8] == crc_high_byte) && (running_crc[7:0] == rx_byte);
    need = {1'b0, committed_bytes} + ((rx_byte == B_SOH) ? 22'd128 : 22'd1024);
    addr = committed_bytes[19:0] + 20'(byte_index - 11'd2);
    if (accept) begin
      if (operation == OP_TIMEOUT) begin
        if (in_packet) begin
          in_packet_next = 1'b0;
          err_req = 1'b1;
        end else begin
          end_req = 1'b1;
          st = ST_IDLE;
        end
      end else if (in_packet) begin
        byte_index_next = byte_index + 11'd1;
        if (byte_index == 11'd0) begin
          block_byte_next = rx_byte;
        end else if (byte_index == 11'd1) begin
          complement_bad_next = (block_byte + rx_byte) != 8'hFF;
        end else if (byte_index < size + 11'd2) begin
          running_crc_next = crc_update(running_crc, rx_byte);
          if (rx_byte != 8'h00) all_zero_next = 1'b0;
          if (!expect_zero && !complement_bad && block_byte == expected_block) begin
            res[0].kind = KIND_DATA;
            res[0].value = rx_byte;
            res[0].address = addr;
            n = 3'd1;
          end
        end else if (byte_index == size + 11'd2) begin
          crc_high_byte_next = rx_byte;
        end else begin
          byte_index_next = byte_index;
          in_packet_next = 1'b0;
          if (expect_zero) begin
            if (block_byte != 8'h00 || complement_bad || !crc_ok) begin
              err_req = 1'b1;
            end else if (all_zero) begin
              res[0] = mk_send(B_ACK);
              n = 3'd1;
              end_req = 1'b1;
              st = ST_OK;
            end else begin
              res[0] = mk_send(B_ACK);
              res[1] = mk_send(B_C);
              n = 3'd2;
              expected_block_next = 8'd1;
              expect_zero_next = 1'b0;
            end
          end else if (complement_bad) begin
            err_req = 1'b1;
          end else if (block_byte != expected_block) begin
            if (block_byte == expected_block - 8'd1) begin
              res[0] = mk_send(B_ACK);
              n = 3'd1;
            end else begin
              cancel_req = 1'b1;
              st = ST_DESYNC;
            end
          end else if (!crc_ok) begin
            err_req = 1'b1;
          end else begin
            committed_bytes_next = committed_bytes + 21'(size);
            expected_block_next = expected_block + 8'd1;
            error_count_next = 4'd0;
            res[0] = mk_send(B_ACK);
            n = 3'd1;
          end
        end
      end else begin
        if (rx_byte == B_EOT) begin
          if (!eot_seen) begin
            res[0] = mk_send(B_NAK);
            n = 3'd1;
            eot_seen_next = 1'b1;
          end else begin
            res[0] = mk_send(B_ACK);
            res[1] = mk_send(B_C);
            n = 3'd2;
            expect_zero_next = 1'b1;
          end
        end else if (rx_byte == B_CAN) begin
          if (!can_seen) begin
            can_seen_next = 1'b1;
            res[0] = mk_send(B_NAK);
            n = 3'd1;
          end else begin
            end_req = 1'b1;
            st = ST_CANCEL;
          end
        end else if (rx_byte == B_SOH || rx_byte == B_STX) begin
          if (need > {1'b0, buffer_size}) begin
            cancel_req = 1'b1;
            st = ST_OVERFLOW;
          end else begin
            eot_seen_next = 1'b0;
            can_seen_next = 1'b0;
            in_packet_next = 1'b1;
            large_packet_next = (rx_byte == B_STX);
            byte_index_next = 11'd0;
            running_crc_next = 16'h0000;
            block_byte_next = 8'h00;
            crc_high_byte_next = 8'h00;
            all_zero_next = 1'b1;
            complement_bad_next = 1'b0;
          end
        end
      end
      if (err_req) begin
        res[n[1:0]] = mk_send(B_NAK);
        n = n + 3'd1;
        ec = (error_count < 4'd15) ? error_count + 4'd1 : error_count;
        error_count_next = ec;
        if (ec >= error_limit) begin
          cancel_req = 1'b1;
          st = ST_ERRLIM;
        end
      end
      if (cancel_req) begin
        res[n[1:0]] = mk_send(B_CAN);
        n = n + 3'd1;
        res[n[1:0]] = mk_send(B_CAN);
        n = n + 3'd1;
        end_req = 1'b1;
      end
      if (end_req) begin
        res[n[1:0]] = '0;
        res[n[1:0]].kind = KIND_END;
        res[n[1:0]].status = st;
        res[n[1:0]].byte_count = committed_bytes;
        n = n + 3'd1;
        in_packet_next = 1'b0;
        expect_zero_next = 1'b1;
        eot_seen_next = 1'b0;
        can_seen_next = 1'b0;
        error_count_next = 4'd0;
        expected_block_next = 8'd1;
        committed_bytes_next = 21'd0;
        byte_index_next = 11'd0;
        large_packet_next = 1'b0;
        running_crc_next = 16'h0000;
        block_byte_next = 8'h00;
        crc_high_byte_next = 8'h00;
        all_zero_next = 1'b1;
        complement_bad_next = 1'b0;
      end
    end
  end

  assign grp_push = accept && (n != 3'd0);
  assign grp.count = n;
  assign grp.res = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= BUFFER_SIZE_RESET;
      error_limit <= ERROR_LIMIT_RESET;
      in_packet <= 1'b0;
      expect_zero <= 1'b1;
      eot_seen <= 1'b0;
      can_seen <= 1'b0;
      error_count <= 4'd0;
      expected_block <= 8'd1;
      committed_bytes <= 21'd0;
      byte_index <= 11'd0;
      large_packet <= 1'b0;
      running_crc <= 16'h0000;
      block_byte <= 8'h00;
      crc_high_byte <= 8'h00;
      all_zero <= 1'b1;
      complement_bad <= 1'b0;
    end else begin
      if (cfg_write && cfg_index == CFG_BUFFER_SIZE) buffer_size <= cfg_data;
      if (cfg_write && cfg_index == CFG_ERROR_LIMIT) error_limit <= cfg_data[3:0];
      in_packet <= in_packet_next;
      expect_zero <= expect_zero_next;
      eot_seen <= eot_seen_next;
      can_seen <= can_seen_next;
      error_count <= error_count_next;
      expected_block <= expected_block_next;
      committed_bytes <= committed_bytes_next;
      byte_index <= byte_index_next;
      large_packet <= large_packet_next;
      running_crc <= running_crc_next;
      block_byte <= block_byte_next;
      crc_high_byte <= crc_high_byte_next;
      all_zero <= all_zero_next;
      complement_bad <= complement_bad_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) byte_index <= 11'd1027)
    else $error("Packet byte index ran past the trailer.");
  assert property (@(posedge clk) disable iff (rst) grp_push |-> n <= 3'd4)
    else $error("More results than a group holds.");
  assert property (@(posedge clk) disable iff (rst)
    (accept && expect_zero && in_packet) |-> !(grp_push && res[0].kind == KIND_DATA))
    else $error("Payload beat emitted for packet zero.");
endmodule

>>> design/ymc_back.sv
`timescale 1ns / 1ps
module ymc_back #(
  parameter int ADDR_BITS = ymc_pkg::ADDR_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic grp_push,
  input  ymc_pkg::group_t grp,
  output logic full,
  output logic empty,
  input  logic pop,
  output logic [1:0] kind,
  output logic [7:0] value,
  output logic [ADDR_BITS-1:0] address,
  output logic [2:0] status,
  output logic [20:0] byte_count,
  output logic last
);
  import ymc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  group_t queue [QUEUE_DEPTH];
  logic [PW-1:0] head, tail;
  logic [PW:0] count;
  logic [1:0] sub;
  result_t cur;
  logic [31:0] addr_wide;
  logic pop_beat, pop_group;

  assign full = (count == (PW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign cur = queue[head].res[sub];
  assign last = ({1'b0, sub} == queue[head].count - 3'd1);
  assign kind = cur.kind;
  assign value = cur.value;
  assign addr_wide = {12'h000, cur.address};
  assign address = addr_wide[ADDR_BITS-1:0];
  assign status = cur.status;
  assign byte_count = cur.byte_count;
  assign pop_beat = pop && !empty;
  assign pop_group = pop_beat && last;

  always_ff @(posedge clk) begin
    if (grp_push) queue[tail] <= grp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
      sub <= 2'd0;
    end else begin
      if (grp_push) tail <= tail + 1'b1;
      if (pop_group) begin
        head <= head + 1'b1;
        sub <= 2'd0;
      end else if (pop_beat) begin
        sub <= sub + 2'd1;
      end
      count <= count + (PW+1)'(grp_push) - (PW+1)'(pop_group);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= (PW+1)'(QUEUE_DEPTH))
    else $error("Result queue overran.");
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> ({1'b0, sub} < queue[head].count))
    else $error("Beat index past the end of its group.");
  assert property (@(posedge clk) disable iff (rst) empty |-> sub == 2'd0)
    else $error("Beat index not cleared with an empty queue.");
endmodule

>>> design/ymodem_crc_receiver.sv
// A result is registered into the result queue by the byte or timeout beat that causes
// it. Throughput: one input beat per cycle while full is low; results leave at one beat
// per cycle, up to four per input, so output draining sets the sustained rate when many
// results are produced. The result queue holds four input groups between the framing
// logic and the output. Reset (synchronous, active high) returns the session state and
// both registers to their defaults and empties the queue; it takes effect at once.
`timescale 1ns / 1ps
module ymodem_crc_receiver #(
  parameter int ADDR_BITS = ymc_pkg::ADDR_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic operation,
  input  logic [7:0] rx_byte,
  output logic empty,
  input  logic pop,
  output logic [1:0] kind,
  output logic [7:0] value,
  output logic [ADDR_BITS-1:0] address,
  output logic [2:0] status,
  output logic [20:0] byte_count,
  output logic last,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [20:0] cfg_data
);
  import ymc_pkg::*;

  logic grp_push;
  group_t grp;

  assign cfg_ready = 1'b1;

  ymc_front u_front (
    .clk(clk),
    .rst(rst),
    .accept(push && !full),
    .operation(operation),
    .rx_byte(rx_byte),
    .cfg_write(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .grp_push(grp_push),
    .grp(grp)
  );

  ymc_back #(.ADDR_BITS(ADDR_BITS)) u_back (
    .clk(clk),
    .rst(rst),
    .grp_push(grp_push),
    .grp(grp),
    .full(full),
    .empty(empty),
    .pop(pop),
    .kind(kind),
    .value(value),
    .address(address),
    .status(status),
    .byte_count(byte_count),
    .last(last)
  );
endmodule

>>> verif/tb_ymodem_crc_receiver.sv
`timescale 1ns / 1ps
module tb_ymodem_crc_receiver;
  import ymc_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [19:0] address;
    logic [2:0]  status;
    logic [20:0] byte_count;
    bit          last;
  } beat_t;

  typedef struct {
    bit         op;
    logic [7:0] rx;
    bit         chk;
    logic [1:0] kind;
    logic [7:0] value;
    logic [2:0] status;
  } row_t;

  typedef enum {FAULT_NONE, FAULT_CRC, FAULT_COMPLEMENT, FAULT_TIMEOUT} fault_t;

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic operation;
  logic [7:0] rx_byte;
  logic empty;
  logic pop;
  logic [1:0] kind;
  logic [7:0] value;
  logic [19:0] address;
  logic [2:0] status;
  logic [20:0] byte_count;
  logic last;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [20:0] cfg_data;

  ymodem_crc_receiver i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .rx_byte(rx_byte), .empty(empty), .pop(pop), .kind(kind), .value(value),
    .address(address), .status(status), .byte_count(byte_count), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predicted receiver state and registers.
  logic [20:0] buf_cap;
  logic [3:0]  err_limit;
  bit          in_pkt, want_zero, eot_flag, can_flag, cmpl_bad, big_pkt, zero_name;
  logic [3:0]  err_cnt;
  logic [7:0]  next_blk, blk_num, crc_hi;
  logic [20:0] committed;
  logic [10:0] idx;
  logic [15:0] crc;

  beat_t step_beats[$];
  beat_t expected_beats[$];
  int    fail_count = 0;
  int    items_done = 0;
  int    idle_cycles = 0;
  bit    steady = 0;
  bit    hold_req = 0;
  int    hold_left = 0;
  int    pop_idle = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      x = x[15] ? ((x << 1) ^ 16'h1021) : (x << 1);
    end
    return x;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function void clear_session();
    in_pkt = 0; want_zero = 1; eot_flag = 0; can_flag = 0; cmpl_bad = 0;
    big_pkt = 0; zero_name = 1; err_cnt = '0; next_blk = 8'd1; blk_num = '0;
    crc_hi = '0; committed = '0; idx = '0; crc = '0;
  endfunction

  function void note(input logic [1:0] k, input logic [7:0] v, input logic [19:0] a,
                     input logic [2:0] s, input logic [20:0] n);
    beat_t t;
    t.kind = k; t.value = v; t.address = a; t.status = s; t.byte_count = n; t.last = 0;
    step_beats.push_back(t);
  endfunction

  function void tx(input logic [7:0] b);
    note(KIND_TX, b, '0, ST_OK, '0);
  endfunction

  function void end_session(input logic [2:0] s);
    note(KIND_END, '0, '0, s, committed);
    clear_session();
  endfunction

  function void cancel_session(input logic [2:0] s);
    tx(B_CAN);
    tx(B_CAN);
    end_session(s);
  endfunction

  function void add_error();
    tx(B_NAK);
    if (err_cnt < 4'd15) err_cnt++;
    if (err_cnt >= err_limit) cancel_session(ST_ERRLIM);
  endfunction

  function void close_packet(input logic [7:0] lo, input int sz);
    bit ok;
    logic [7:0] prev;
    ok = (crc[15:8] == crc_hi) && (crc[7:0] == lo);
    prev = next_blk - 8'd1;
    in_pkt = 0;
    if (want_zero) begin
      if (blk_num != 8'd0 || cmpl_bad || !ok) begin
        add_error();
      end else if (zero_name) begin
        tx(B_ACK);
        end_session(ST_OK);
      end else begin
        tx(B_ACK);
        tx(B_C);
        next_blk = 8'd1;
        want_zero = 0;
      end
    end else if (cmpl_bad) begin
      add_error();
    end else if (blk_num != next_blk) begin
      if (blk_num == prev) tx(B_ACK);
      else cancel_session(ST_DESYNC);
    end else if (!ok) begin
      add_error();
    end else begin
      committed = committed + 21'(sz);
      next_blk = next_blk + 8'd1;
      err_cnt = '0;
      tx(B_ACK);
    end
  endfunction

  function void packet_byte(input logic [7:0] b);
    int sz;
    sz = big_pkt ? 1024 : 128;
    if (idx == 0) begin
      blk_num = b;
    end else if (idx == 1) begin
      cmpl_bad = (8'(blk_num + b) != 8'hFF);
    end else if (int'(idx) < sz + 2) begin
      crc = crc16_next(crc, b);
      if (b != 8'd0) zero_name = 0;
      if (!want_zero && !cmpl_bad && blk_num == next_blk)
        note(KIND_DATA, b, 20'(int'(committed) + int'(idx) - 2), ST_OK, '0);
    end else if (int'(idx) == sz + 2) begin
      crc_hi = b;
    end else begin
      close_packet(b, sz);
      return;
    end
    idx++;
  endfunction

  function void header_byte(input logic [7:0] b);
    int sz;
    if (b == B_EOT) begin
      if (!eot_flag) begin
        tx(B_NAK);
        eot_flag = 1;
      end else begin
        tx(B_ACK);
        tx(B_C);
        want_zero = 1;
      end
      return;
    end
    if (b == B_CAN) begin
      if (!can_flag) begin
        can_flag = 1;
        tx(B_NAK);
      end else begin
        end_session(ST_CANCEL);
      end
      return;
    end
    if (b != B_SOH && b != B_STX) return;
    sz = (b == B_SOH) ? 128 : 1024;
    if (int'(committed) + sz > int'(buf_cap)) begin
      cancel_session(ST_OVERFLOW);
      return;
    end
    eot_flag = 0; can_flag = 0; in_pkt = 1; big_pkt = (b == B_STX);
    idx = '0; crc = '0; blk_num = '0; crc_hi = '0; zero_name = 1; cmpl_bad = 0;
  endfunction

  function void predict_item(input bit op, input logic [7:0] b);
    step_beats.delete();
    if (op == OP_TIMEOUT) begin
      if (in_pkt) begin
        in_pkt = 0;
        add_error();
      end else begin
        end_session(ST_IDLE);
      end
    end else if (in_pkt) begin
      packet_byte(b);
    end else begin
      header_byte(b);
    end
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1;
    foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
  endfunction

  task automatic put_item(input bit op, input logic [7:0] b);
    int g;
    g = steady ? 0 : gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push <= 1'b1;
    operation <= op;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_item(op, b);
    items_done++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] ix, input logic [20:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (ix == CFG_BUFFER_SIZE) buf_cap = d;
    else if (ix == CFG_ERROR_LIMIT) err_limit = d[3:0];
  endtask

  task automatic send_packet(input bit big, input logic [7:0] blk, input fault_t fault,
                             input bit zero_body, input int cut_max);
    int sz;
    int cut;
    logic [15:0] c;
    logic [7:0] d;
    sz = big ? 1024 : 128;
    cut = $urandom_range(0, (cut_max < sz + 3) ? cut_max : sz + 3);
    c = '0;
    steady = ($urandom_range(0, 3) == 0);
    put_item(OP_BYTE, big ? B_STX : B_SOH);
    for (int pos = 0; pos <= sz + 3; pos++) begin
      if (fault == FAULT_TIMEOUT && pos == cut) begin
        put_item(OP_TIMEOUT, 8'($urandom));
        return;
      end
      if (pos == 0) begin
        d = blk;
      end else if (pos == 1) begin
        d = ~blk;
        if (fault == FAULT_COMPLEMENT) d = d ^ (8'd1 << $urandom_range(0, 7));
      end else if (pos < sz + 2) begin
        d = (zero_body || $urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom);
        c = crc16_next(c, d);
      end else if (pos == sz + 2) begin
        d = c[15:8];
      end else begin
        d = c[7:0];
        if (fault == FAULT_CRC) d = d ^ 8'($urandom_range(1, 255));
      end
      put_item(OP_BYTE, d);
    end
  endtask

  task automatic random_traffic(input int budget);
    int stop_at;
    int r;
    int room;
    int lim;
    bit big;
    logic [7:0] blk;
    fault_t f;
    stop_at = items_done + budget;
    while (items_done < stop_at) begin
      room = stop_at - items_done;
      lim = (room > 2) ? room - 2 : 0;
      r = $urandom_range(0, 99);
      big = ($urandom_range(0, 11) == 0);
      blk = want_zero ? 8'd0 : next_blk;
      if (r < 55) begin
        if (room < (big ? 1032 : 132)) begin
          send_packet(big, blk, FAULT_TIMEOUT, 1'b0, lim);
        end else begin
          send_packet(big, blk, FAULT_NONE, want_zero && $urandom_range(0, 3) == 0, lim);
        end
      end else if (r < 66) begin
        f = fault_t'($urandom_range(1, 3));
        if (room < 132) f = FAULT_TIMEOUT;
        if ($urandom_range(0, 3) == 0) blk = 8'($urandom);
        send_packet(1'b0, blk, f, 1'b0, lim);
      end else if (r < 71) begin
        send_packet(1'b0, next_blk - 8'd1, (room < 132) ? FAULT_TIMEOUT : FAULT_NONE,
                    1'b0, lim);
      end else if (r < 77) begin
        put_item(OP_BYTE, B_EOT);
      end else if (r < 82) begin
        put_item(OP_BYTE, B_CAN);
      end else if (r < 85) begin
        put_item(OP_TIMEOUT, 8'($urandom));
      end else begin
        put_item(OP_BYTE, 8'($urandom));
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (pop_idle > 0) begin
      pop_idle--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      pop_idle = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
    end
  end

  always @(posedge clk) begin
    beat_t e;
    if (!rst && pop && !empty) begin
      if (expected_beats.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat kind %0d value %02h", kind, value));
      end else begin
        e = expected_beats.pop_front();
        if (kind !== e.kind) flag_mismatch($sformatf("kind %0d, want %0d", kind, e.kind));
        if (value !== e.value)
          flag_mismatch($sformatf("value %02h, want %02h", value, e.value));
        if (address !== e.address)
          flag_mismatch($sformatf("address %0d, want %0d", address, e.address));
        if (status !== e.status)
          flag_mismatch($sformatf("status %0d, want %0d", status, e.status));
        if (byte_count !== e.byte_count)
          flag_mismatch($sformatf("byte_count %0d, want %0d", byte_count, e.byte_count));
        if (last !== e.last) flag_mismatch($sformatf("last %0b, want %0b", last, e.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 3000) begin
      $display("ymodem_crc_receiver test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  row_t directed[] = '{
    '{OP_TIMEOUT, 8'h00, 1, KIND_END, 8'h00, ST_IDLE},
    '{OP_BYTE,    8'hFF, 0, KIND_TX,  8'h00, ST_OK},
    '{OP_BYTE,    8'h00, 0, KIND_TX,  8'h00, ST_OK},
    '{OP_BYTE,    B_EOT, 1, KIND_TX,  B_NAK, ST_OK},
    '{OP_BYTE,    B_EOT, 1, KIND_TX,  B_C,   ST_OK},
    '{OP_BYTE,    B_CAN, 1, KIND_TX,  B_NAK, ST_OK},
    '{OP_BYTE,    B_CAN, 1, KIND_END, 8'h00, ST_CANCEL},
    '{OP_BYTE,    B_SOH, 0, KIND_TX,  8'h00, ST_OK},
    '{OP_BYTE,    8'h00, 0, KIND_TX,  8'h00, ST_OK},
    '{OP_BYTE,    8'hFF, 0, KIND_TX,  8'h00, ST_OK},
    '{OP_BYTE,    8'h80, 0, KIND_TX,  8'h00, ST_OK},
    '{OP_TIMEOUT, 8'hFF, 1, KIND_TX,  B_NAK, ST_OK},
    '{OP_BYTE,    B_STX, 0, KIND_TX,  8'h00, ST_OK},
    '{OP_BYTE,    8'h01, 0, KIND_TX,  8'h00, ST_OK},
    '{OP_BYTE,    8'h00, 0, KIND_TX,  8'h00, ST_OK},
    '{OP_TIMEOUT, 8'h55, 1, KIND_TX,  B_NAK, ST_OK},
    '{OP_BYTE,    B_CAN, 1, KIND_TX,  B_NAK, ST_OK},
    '{OP_BYTE,    B_CAN, 1, KIND_END, 8'h00, ST_CANCEL}
  };

  initial begin
    rst = 1'b1;
    push = 1'b0;
    operation = 1'b0;
    rx_byte = '0;
    pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    buf_cap = BUFFER_SIZE_RESET;
    err_limit = ERROR_LIMIT_RESET;
    clear_session();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      put_item(directed[i].op, directed[i].rx);
      if (directed[i].chk) begin
        if (step_beats.size() == 0 || step_beats[step_beats.size() - 1].kind != directed[i].kind
            || step_beats[step_beats.size() - 1].value != directed[i].value
            || step_beats[step_beats.size() - 1].status != directed[i].status)
          flag_mismatch($sformatf("directed row %0d predicts a different beat", i));
      end
    end
    random_traffic(140);
    wait_drained();

    write_reg(CFG_BUFFER_SIZE, 21'd300);
    write_reg(CFG_ERROR_LIMIT, 21'd1);
    random_traffic(100);
    wait_drained();

    write_reg(CFG_BUFFER_SIZE, 21'd0);
    write_reg(CFG_ERROR_LIMIT, 21'd15);
    random_traffic(30);
    wait_drained();

    write_reg(CFG_BUFFER_SIZE, 21'd1048576);
    write_reg(CFG_ERROR_LIMIT, 21'd10);
    hold_req = 1;
    random_traffic(140);
    wait_drained();

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ymodem_crc_receiver test passed");
    end else begin
      $display("ymodem_crc_receiver test failed");
    end
    $finish;
  end

endmodule
